// ===== hdl/spf_pkg.sv =====
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and the byte-wide CRC-16 update for the servo
// packet framer.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int FRAME_BUFFER_BYTES = 256;
    localparam int FRAME_OVERHEAD     = 10;
    localparam logic [7:0] COUNT_LIMIT = 8'(FRAME_BUFFER_BYTES - FRAME_OVERHEAD);

    localparam logic [15:0] CRC_POLY  = 16'h8005;
    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  MARK_BYTE = 8'hFD;
    localparam logic [7:0]  RSVD_BYTE = 8'h00;
    localparam logic [8:0]  LEN_EXTRA = 9'd3;

    typedef struct packed {
        logic [7:0] servo_id;
        logic [7:0] instruction;
        logic [7:0] param_count;
        logic [7:0] param_value;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_end;
    } result_t;

    // One classified item, as handed from the front end to the byte sequencer.
    typedef struct packed {
        logic       is_start;
        logic       has_param;
        logic       close;
        logic [7:0] servo_id;
        logic [7:0] instruction;
        logic [8:0] len;
        logic [7:0] param_value;
    } cmd_t;

    // MSB-first CRC-16 update over one byte, no reflection.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/servo_packet_framer_crc16.sv =====
// With the sequencer idle, an item's first byte passes the command queue and
// then the result queue registers on its way to the result ports. A single
// byte-wide sequencer gives one byte per cycle while a command waits and the
// result queue has room; a two-entry command queue lets input run ahead. A
// parameter item gives its byte (plus CRC on close); a start adds the header.
// Reset: asynchronous, active low; clears packet state, CRC and both queues.
// ----------------------------------------------------------------------------
// servo_packet_framer_crc16
// Servo bus packet framer: header, id, length, instruction, parameters and a
// trailing CRC-16, one byte per result item.
// ----------------------------------------------------------------------------
module servo_packet_framer_crc16 (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  spf_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output spf_pkg::result_t result
);

    spf_pkg::cmd_t front_cmd;
    spf_pkg::cmd_t head_cmd;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;

    spf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (front_cmd)
    );

    spf_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .full    (cmd_full),
        .wr_data (front_cmd),
        .empty   (cmd_empty),
        .pop     (cmd_pop),
        .rd_data (head_cmd)
    );

    spf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== hdl/spf_front.sv =====
// ----------------------------------------------------------------------------
// spf_front
// Accepts input items, tracks packet state and turns each item into one
// command for the byte sequencer.
// ----------------------------------------------------------------------------
module spf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  spf_pkg::item_t item,
    output logic          cmd_push,
    input  logic          cmd_full,
    output spf_pkg::cmd_t cmd
);

    logic       in_packet_reg, in_packet_next;
    logic [7:0] params_left_reg, params_left_next;
    logic [7:0] count_sat;
    logic       accept;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    assign count_sat = (item.param_count > spf_pkg::COUNT_LIMIT) ?
                       spf_pkg::COUNT_LIMIT : item.param_count;

    always_comb
    begin
        cmd.servo_id    = item.servo_id;
        cmd.instruction = item.instruction;
        cmd.param_value = item.param_value;
        cmd.len         = {1'b0, count_sat} + spf_pkg::LEN_EXTRA;
        if (!in_packet_reg)
        begin
            cmd.is_start     = 1'b1;
            cmd.has_param    = (count_sat != 8'd0);
            cmd.close        = (count_sat <= 8'd1);
            params_left_next = (count_sat == 8'd0) ? 8'd0 : count_sat - 8'd1;
        end
        else
        begin
            cmd.is_start     = 1'b0;
            cmd.has_param    = 1'b1;
            // A count that is already zero stays there and still closes.
            cmd.close        = (params_left_reg <= 8'd1);
            params_left_next = (params_left_reg == 8'd0) ? 8'd0 : params_left_reg - 8'd1;
        end
        in_packet_next = !cmd.close;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg   <= 1'b0;
            params_left_reg <= 8'd0;
        end
        else if (accept)
        begin
            in_packet_reg   <= in_packet_next;
            params_left_reg <= params_left_next;
        end
    end

endmodule

// ===== hdl/spf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// spf_cmd_queue
// Two-entry command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module spf_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  spf_pkg::cmd_t wr_data,
    output logic          empty,
    input  logic          pop,
    output spf_pkg::cmd_t rd_data
);

    spf_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/spf_back.sv =====
// ----------------------------------------------------------------------------
// spf_back
// Byte sequencer: expands each command into packet bytes, keeps the running
// CRC and feeds a two-entry result queue.
// ----------------------------------------------------------------------------
module spf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    input  spf_pkg::cmd_t   cmd,
    output logic            empty,
    input  logic            pop,
    output spf_pkg::result_t result
);

    typedef enum logic [3:0] {
        ST_HDR0,
        ST_HDR1,
        ST_HDR2,
        ST_HDR3,
        ST_ID,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_INSTR,
        ST_PARAM,
        ST_CRC_LO,
        ST_CRC_HI
    } step_t;

    step_t       step_reg, step_next, cur_step;
    logic        active_reg;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  byte_val;
    logic        hashed;
    logic        last;

    spf_pkg::result_t res_reg [2];
    logic             res_wr_ptr_reg;
    logic             res_rd_ptr_reg;
    logic [1:0]       res_count_reg, res_count_next;
    logic             res_full;
    logic             emit;
    logic             do_pop;

    assign res_full = (res_count_reg == 2'd2);
    assign empty    = (res_count_reg == 2'd0);
    assign do_pop   = pop && !empty;
    assign result   = res_reg[res_rd_ptr_reg];
    assign emit     = !cmd_empty && !res_full;
    assign cmd_pop  = emit && last;

    always_comb
    begin
        if (active_reg)
            cur_step = step_reg;
        else if (cmd.is_start)
            cur_step = ST_HDR0;
        else
            cur_step = ST_PARAM;
    end

    always_comb
    begin
        byte_val  = spf_pkg::RSVD_BYTE;
        hashed    = 1'b1;
        last      = 1'b0;
        step_next = cur_step;
        case (cur_step)
            ST_HDR0:
            begin
                byte_val  = spf_pkg::SYNC_BYTE;
                step_next = ST_HDR1;
            end
            ST_HDR1:
            begin
                byte_val  = spf_pkg::SYNC_BYTE;
                step_next = ST_HDR2;
            end
            ST_HDR2:
            begin
                byte_val  = spf_pkg::MARK_BYTE;
                step_next = ST_HDR3;
            end
            ST_HDR3:
            begin
                byte_val  = spf_pkg::RSVD_BYTE;
                step_next = ST_ID;
            end
            ST_ID:
            begin
                byte_val  = cmd.servo_id;
                step_next = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                byte_val  = cmd.len[7:0];
                step_next = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                byte_val  = {7'd0, cmd.len[8]};
                step_next = ST_INSTR;
            end
            ST_INSTR:
            begin
                byte_val  = cmd.instruction;
                step_next = cmd.has_param ? ST_PARAM : ST_CRC_LO;
            end
            ST_PARAM:
            begin
                byte_val  = cmd.param_value;
                step_next = ST_CRC_LO;
                last      = !cmd.close;
            end
            ST_CRC_LO:
            begin
                byte_val  = crc_reg[7:0];
                hashed    = 1'b0;
                step_next = ST_CRC_HI;
            end
            ST_CRC_HI:
            begin
                byte_val  = crc_reg[15:8];
                hashed    = 1'b0;
                step_next = ST_HDR0;
                last      = 1'b1;
            end
            default:
            begin
                byte_val  = spf_pkg::RSVD_BYTE;
                step_next = ST_HDR0;
            end
        endcase
    end

    // A new packet restarts the CRC from zero on its first header byte.
    always_comb
    begin
        if (!hashed)
            crc_next = crc_reg;
        else if (cur_step == ST_HDR0)
            crc_next = spf_pkg::crc16_byte(16'h0000, byte_val);
        else
            crc_next = spf_pkg::crc16_byte(crc_reg, byte_val);
    end

    always_comb
    begin
        res_count_next = res_count_reg;
        if (emit && !do_pop)
            res_count_next = res_count_reg + 2'd1;
        else if (do_pop && !emit)
            res_count_next = res_count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            step_reg       <= ST_HDR0;
            crc_reg        <= 16'h0000;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            res_count_reg <= res_count_next;
            if (do_pop)
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            if (emit)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
                crc_reg        <= crc_next;
                active_reg     <= !last;
                step_reg       <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg[res_wr_ptr_reg].out_byte   <= byte_val;
            res_reg[res_wr_ptr_reg].packet_end <= (cur_step == ST_CRC_HI);
            res_reg[res_wr_ptr_reg].run_end    <= last;
        end
    end

endmodule
